[sv/table_round_block_cipher_assert.svh]
// assertion macros for the table round block cipher
`ifndef TABLE_ROUND_BLOCK_CIPHER_ASSERT_SVH
`define TABLE_ROUND_BLOCK_CIPHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TRBC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TRBC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRBC_ASSERT(label, clk, rst_n, prop, msg)
`define TRBC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/trbc_pkg.sv]
// types, constants and substitution boxes of the table round block cipher
package trbc_pkg;
  localparam int KeyBits = 80;
  localparam int BlkBits = 64;
  localparam int PreRot = 13;

  localparam logic [1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [1:0] REG_KEY_LOWER = 2'd1;
  localparam logic [1:0] REG_LAST_ROUND = 2'd2;
  localparam logic [1:0] REG_PERMUTED = 2'd3;

  typedef struct packed {
    logic       mode;
    logic       base;
    logic [7:0] last;
  } ctrl_t;

  localparam logic [2:0] ORDER [24] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd3, 3'd6, 3'd1, 3'd4, 3'd7, 3'd2, 3'd5};

  localparam logic [7:0] BOX_ODD [256] = '{
    8'hDA,8'h26,8'hE8,8'h72,8'h11,8'h52,8'h3E,8'h46,8'h32,8'hFF,8'h8C,8'h1E,8'hA7,8'hBE,8'h2C,8'h29,
    8'h5F,8'h86,8'h7E,8'h75,8'h0A,8'h08,8'hA5,8'h21,8'h61,8'hFB,8'h7A,8'h58,8'h60,8'hF7,8'h81,8'h4F,
    8'hE4,8'hFC,8'hDF,8'hB1,8'hBB,8'h6A,8'h02,8'hB3,8'h0B,8'h6E,8'h5D,8'h5C,8'hD5,8'hCF,8'hCA,8'h2A,
    8'h14,8'hB7,8'h90,8'hF3,8'hD9,8'h37,8'h3A,8'h59,8'h44,8'h69,8'hC9,8'h78,8'h30,8'h16,8'h39,8'h9A,
    8'h0D,8'h05,8'h1F,8'h8B,8'h5E,8'hEE,8'h1B,8'hC4,8'h76,8'h43,8'hBD,8'hEB,8'h42,8'hEF,8'hF9,8'hD0,
    8'h4D,8'hE3,8'hF4,8'h57,8'h56,8'hA3,8'h0F,8'hA6,8'h50,8'hFD,8'hDE,8'hD2,8'h80,8'h4C,8'hD3,8'hCB,
    8'hF8,8'h49,8'h8F,8'h22,8'h71,8'h84,8'h33,8'hE0,8'h47,8'hC2,8'h93,8'hBC,8'h7C,8'h3B,8'h9C,8'h7D,
    8'hEC,8'hC3,8'hF1,8'h89,8'hCE,8'h98,8'hA2,8'hE1,8'hC1,8'hF2,8'h27,8'h12,8'h01,8'hEA,8'hE5,8'h9B,
    8'h25,8'h87,8'h96,8'h7B,8'h34,8'h45,8'hAD,8'hD1,8'hB5,8'hDB,8'h83,8'h55,8'hB0,8'h9E,8'h19,8'hD7,
    8'h17,8'hC6,8'h35,8'hD8,8'hF0,8'hAE,8'hD4,8'h2B,8'h1D,8'hA0,8'h99,8'h8A,8'h15,8'h00,8'hAF,8'h2D,
    8'h09,8'hA8,8'hF5,8'h6C,8'hA1,8'h63,8'h67,8'h51,8'h3C,8'hB2,8'hC0,8'hED,8'h94,8'h03,8'h6F,8'hBA,
    8'h3F,8'h4E,8'h62,8'h92,8'h85,8'hDD,8'hAB,8'hFE,8'h10,8'h2E,8'h68,8'h65,8'hE7,8'h04,8'hF6,8'h0C,
    8'h20,8'h1C,8'hA9,8'h53,8'h40,8'h77,8'h2F,8'hA4,8'hFA,8'h6D,8'h73,8'h28,8'hE2,8'hCD,8'h79,8'hC8,
    8'h97,8'h66,8'h8E,8'h82,8'h74,8'h06,8'hC7,8'h88,8'h1A,8'h4A,8'h6B,8'hCC,8'h41,8'hE9,8'h9D,8'hB8,
    8'h23,8'h9F,8'h3D,8'hBF,8'h8D,8'h95,8'hC5,8'h13,8'hB9,8'h24,8'h5A,8'hDC,8'h64,8'h18,8'h38,8'h91,
    8'h7F,8'h5B,8'h70,8'h54,8'h07,8'hB6,8'h4B,8'h0E,8'h36,8'hAC,8'h31,8'hE6,8'hD6,8'h48,8'hAA,8'hB4};

  localparam logic [7:0] BOX_EVEN [256] = '{
    8'h8E,8'hD5,8'h32,8'h53,8'h4B,8'h18,8'h7F,8'h95,8'hBE,8'h30,8'hF3,8'hE0,8'h22,8'hE1,8'h68,8'h90,
    8'h82,8'hC8,8'hA8,8'h57,8'h21,8'hC5,8'h38,8'h73,8'h61,8'h5D,8'h5A,8'hD6,8'h60,8'hB7,8'h48,8'h70,
    8'h2B,8'h7A,8'h1D,8'hD1,8'hB1,8'hEC,8'h7C,8'hAA,8'h2F,8'h1F,8'h37,8'h58,8'h72,8'h88,8'hFF,8'h87,
    8'h1C,8'hCB,8'h00,8'hE6,8'h4E,8'hAB,8'hEB,8'hB3,8'hF7,8'h59,8'h71,8'h6A,8'h64,8'h2A,8'h55,8'h4D,
    8'hFC,8'hC0,8'h51,8'h01,8'h2D,8'hC4,8'h54,8'hE2,8'h9F,8'h26,8'h16,8'h27,8'hF2,8'h9C,8'h86,8'h11,
    8'h05,8'h29,8'hA2,8'h78,8'h49,8'hB2,8'hA6,8'hCA,8'h96,8'hE5,8'h33,8'h3F,8'h46,8'hBA,8'hD0,8'hBB,
    8'h5F,8'h84,8'h98,8'hE4,8'hF9,8'h0A,8'h62,8'hEE,8'hF6,8'hCF,8'h94,8'hF0,8'hEA,8'h1E,8'hBF,8'h07,
    8'h9B,8'hD9,8'hE9,8'h74,8'hC6,8'hA4,8'hB9,8'h56,8'h3E,8'hDB,8'hC7,8'h15,8'hE3,8'h80,8'hD7,8'hED,
    8'hEF,8'h13,8'hAC,8'hA1,8'h91,8'hC2,8'h89,8'h5B,8'h08,8'h0B,8'h4C,8'h02,8'h3A,8'h5C,8'hA9,8'h3B,
    8'hCE,8'h6B,8'hA7,8'hE7,8'hCD,8'h7B,8'hA0,8'h47,8'h09,8'h6D,8'hF8,8'hF1,8'h8B,8'hB0,8'h12,8'h42,
    8'h4A,8'h9A,8'h17,8'hB4,8'h7E,8'hAD,8'hFE,8'hFD,8'h2C,8'hD3,8'hF4,8'hB6,8'hA3,8'hFA,8'hDF,8'hB8,
    8'hD4,8'hDA,8'h0F,8'h50,8'h93,8'h66,8'h6C,8'h20,8'hD8,8'h8A,8'hDD,8'h31,8'h1A,8'h8C,8'h06,8'hD2,
    8'h44,8'hE8,8'h23,8'h43,8'h6E,8'h10,8'h69,8'h36,8'hBC,8'h19,8'h8D,8'h24,8'h81,8'h14,8'h40,8'hC9,
    8'h6F,8'h2E,8'h45,8'h52,8'h41,8'h92,8'h34,8'hFB,8'h5E,8'h0D,8'hF5,8'h76,8'h25,8'h77,8'h63,8'h65,
    8'hAF,8'h4F,8'hCC,8'h03,8'h9D,8'h0C,8'h28,8'h39,8'h85,8'hDE,8'hB5,8'h7D,8'h67,8'h83,8'hBD,8'hC3,
    8'hDC,8'h3C,8'hAE,8'h99,8'h04,8'h75,8'h8F,8'h97,8'hC1,8'hA5,8'h9E,8'h35,8'h0E,8'h3D,8'h1B,8'h79};
endpackage

[sv/trbc_if.sv]
// valid/ready channel interfaces
interface trbc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] block_in;
  modport source (output valid, mode, block_in, input ready);
  modport sink (input valid, mode, block_in, output ready);
endinterface

interface trbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;
  modport source (output valid, block_out, input ready);
  modport sink (input valid, block_out, output ready);
endinterface

interface trbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/trbc_key_sched.sv]
// working key shift register: one bit rotation per cycle while rot_r or rot_l is high
module trbc_key_sched (
  input  logic                  clk,
  input  logic                  load,
  input  logic [79:0]           key,
  input  logic                  rot_r,
  input  logic                  rot_l,
  input  logic [3:0]            sel,
  output logic [7:0]            kbyte
);
  import trbc_pkg::*;
  logic [KeyBits-1:0] key_r, key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (load) begin
      key_nxt = key;
    end else if (rot_r) begin
      key_nxt = {key_r[0], key_r[KeyBits-1:1]};
    end else if (rot_l) begin
      key_nxt = {key_r[KeyBits-2:0], key_r[KeyBits-1]};
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // byte 0 sits in the top bits
  assign kbyte = key_r[KeyBits-1-8*sel -: 8];
endmodule

[sv/trbc_round.sv]
// block register and one byte-wide table round per cycle while en is high
module trbc_round (
  input  logic        clk,
  input  logic        load,
  input  logic [63:0] blk_in,
  input  logic        en,
  input  logic [7:0]  kbyte,
  input  logic [3:0]  rmod16,
  input  logic        base,
  output logic [63:0] blk
);
  import trbc_pkg::*;
  logic [7:0] b_r [8];
  logic [7:0] b_nxt [8];
  logic [2:0] src, dst;
  logic [3:0] r1;
  logic [7:0] idx, sv;

  always_comb begin
    r1 = rmod16 + 4'd1;
    src = ORDER[{1'b0, rmod16} + (base ? 5'd8 : 5'd0)];
    dst = ORDER[{1'b0, r1} + (base ? 5'd8 : 5'd0)];
    idx = b_r[src] ^ kbyte;
    sv = kbyte[0] ? BOX_ODD[idx] : BOX_EVEN[idx];
    for (int i = 0; i < 8; i++) begin
      if (load) begin
        b_nxt[i] = blk_in[63-8*i -: 8];
      end else if (en && dst == 3'(i)) begin
        b_nxt[i] = b_r[i] ^ sv;
      end else begin
        b_nxt[i] = b_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) b_r[i] <= b_nxt[i];
  end

  always_comb begin
    for (int i = 0; i < 8; i++) blk[63-8*i -: 8] = b_r[i];
  end
endmodule

[sv/table_round_block_cipher.sv]
// top level: configuration, sequencer, key register and round unit
//  channel | dir | beat
//  in_     | in  | mode, block_in
//  out_    | out | block_out
//  cfg_    | in  | index, data
// decrypt: a right-rotate step before each round r with r mod 10 == 0, then the round;
// rounds run from 0 up to last_round, and the result is then offered on out_.
// encrypt: PreRot right pre-rotations (the round index mod 10 is reduced during them),
// then rounds from last_round down to 0, with a left-rotate after each r mod 10 == 0.
// the result waits in the block register; a stalled out_ holds it and no new beat
// is taken until it has gone. reset (rst_n low, synchronous) restores the defaults.
module table_round_block_cipher (
  input  logic clk,
  input  logic rst_n,
  trbc_in_if.sink    in_ch,
  trbc_out_if.source out_ch,
  trbc_cfg_if.sink   cfg_ch
);
  import trbc_pkg::*;
  `include "table_round_block_cipher_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE = 3'd1;
  localparam logic [2:0] ST_RND = 3'd2;
  localparam logic [2:0] ST_ROTL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [63:0] ku_r;
  logic [15:0] kl_r;
  logic [7:0]  last_r;
  logic        perm_r;
  logic [2:0]  st_r, st_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [3:0]  m10_r, m10_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  md_r, md_nxt;
  logic        fresh_r, fresh_nxt;
  ctrl_t       ctl_r;
  logic        acc, rot_r_s, rot_l_s, en;
  logic [7:0]  kbyte;
  logic [63:0] blk;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (st_r == ST_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (st_r == ST_DONE);
  assign out_ch.block_out = blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ku_r <= '0;
      kl_r <= '0;
      last_r <= 8'd127;
      perm_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KEY_UPPER:  ku_r <= cfg_ch.data;
        REG_KEY_LOWER:  kl_r <= cfg_ch.data[15:0];
        REG_LAST_ROUND: last_r <= cfg_ch.data[7:0];
        REG_PERMUTED:   perm_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    rnd_nxt = rnd_r;
    m10_nxt = m10_r;
    cnt_nxt = cnt_r;
    md_nxt = md_r;
    fresh_nxt = 1'b0;
    rot_r_s = 1'b0;
    rot_l_s = 1'b0;
    en = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          cnt_nxt = 4'd0;
          md_nxt = last_r;
          if (in_ch.mode) begin
            st_nxt = ST_PRE;
            rnd_nxt = last_r;
          end else begin
            st_nxt = ST_RND;
            rnd_nxt = 8'd0;
            m10_nxt = 4'd0;
          end
        end
      end
      ST_PRE: begin
        rot_r_s = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        // restoring reduction by 160, 80, 40, 20 and 10 leaves the index mod 10
        if (cnt_r < 4'd5 && md_r >= (8'd160 >> cnt_r)) md_nxt = md_r - (8'd160 >> cnt_r);
        if (cnt_r == 4'(PreRot - 1)) begin
          st_nxt = ST_RND;
          m10_nxt = md_r[3:0];
        end
      end
      ST_RND: begin
        en = 1'b1;
        if (!ctl_r.mode) begin
          // decrypt rotates before the round that uses the key byte
          rot_r_s = (m10_r == 4'd0) && fresh_r;
          if (m10_r == 4'd0 && !fresh_r) begin
            en = 1'b0;
            rot_r_s = 1'b1;
            fresh_nxt = 1'b1;
          end else begin
            en = 1'b1;
            rot_r_s = 1'b0;
            if (rnd_r == ctl_r.last) st_nxt = ST_DONE;
            rnd_nxt = rnd_r + 8'd1;
            m10_nxt = (m10_r == 4'd9) ? 4'd0 : m10_r + 4'd1;
          end
        end else begin
          if (m10_r == 4'd0) st_nxt = ST_ROTL;
          else begin
            rnd_nxt = rnd_r - 8'd1;
            m10_nxt = m10_r - 4'd1;
          end
          if (rnd_r == 8'd0) st_nxt = ST_ROTL;
        end
      end
      ST_ROTL: begin
        rot_l_s = 1'b1;
        if (rnd_r == 8'd0) st_nxt = ST_DONE;
        else begin
          st_nxt = ST_RND;
          rnd_nxt = rnd_r - 8'd1;
          m10_nxt = 4'd9;
        end
      end
      ST_DONE: begin
        if (out_ch.ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      fresh_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fresh_r <= fresh_nxt;
    end
    rnd_r <= rnd_nxt;
    m10_r <= m10_nxt;
    cnt_r <= cnt_nxt;
    md_r <= md_nxt;
    if (acc) begin
      ctl_r.mode <= in_ch.mode;
      ctl_r.base <= perm_r;
      ctl_r.last <= last_r;
    end
  end

  trbc_key_sched u_key (
    .clk(clk), .load(acc), .key({ku_r, kl_r}),
    .rot_r(rot_r_s), .rot_l(rot_l_s), .sel(m10_r), .kbyte(kbyte)
  );

  trbc_round u_rnd (
    .clk(clk), .load(acc), .blk_in(in_ch.block_in), .en(en), .kbyte(kbyte),
    .rmod16(rnd_r[3:0]), .base(ctl_r.base), .blk(blk)
  );

  // decrypt round zero always needs the fresh rotation first
  `TRBC_ASSERT(a_acc_idle, clk, rst_n, acc |-> st_r == ST_IDLE, "accept outside idle")
  `TRBC_ASSERT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.block_out), "result dropped")
  `TRBC_ASSERT(a_no_both, clk, rst_n, !(rot_r_s && rot_l_s), "two rotations at once")
  `TRBC_ASSERT(a_pre_len, clk, rst_n, st_r == ST_PRE |-> cnt_r < 4'(PreRot), "pre rotation overrun")
endmodule
